/* rtl/core/cau_pkg.sv */
// Shared types and default sizes for the complex arithmetic unit.
`default_nettype none
package cau_pkg;
	localparam int PART_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_SUB,
		CMD_MUL,
		CMD_DIV
	} cmd_t;
endpackage
`default_nettype wire

/* rtl/core/cau_div_cell.sv */
// One restoring-divider cell: retires one quotient bit and hands on to the next cell.
`default_nettype none
module cau_div_cell #(
	parameter int PART_WIDTH = cau_pkg::PART_WIDTH_DEF
) (
	input  wire                      clk,
	input  wire [2*PART_WIDTH-1:0]   rem_i,
	input  wire [PART_WIDTH:0]       x_i,
	input  wire [PART_WIDTH:0]       q_i,
	input  wire [2*PART_WIDTH-1:0]   d_i,
	output logic [2*PART_WIDTH-1:0]  rem_o,
	output logic [PART_WIDTH:0]      x_o,
	output logic [PART_WIDTH:0]      q_o,
	output logic [2*PART_WIDTH-1:0]  d_o
);
	localparam int RW = 2 * PART_WIDTH;

	logic [RW:0]   trial;
	logic [RW:0]   diff;
	logic          ge;
	logic [RW-1:0] rem_n;

	always_comb begin
		trial = {rem_i, x_i[PART_WIDTH]};
		diff  = trial - {1'b0, d_i};
		ge    = trial >= {1'b0, d_i};
		rem_n = ge ? diff[RW-1:0] : trial[RW-1:0];
	end

	always_ff @(posedge clk) begin
		rem_o <= rem_n;
		x_o   <= {x_i[PART_WIDTH-1:0], 1'b0};
		q_o   <= {q_i[PART_WIDTH-1:0], ge};
		d_o   <= d_i;
	end
endmodule
`default_nettype wire

/* rtl/core/complex_arith_unit_top.sv */
// Complex ALU top: product stage, combine stage, divider cell chain and output register.
// A start beat passes the stage registers, cell chain and output register to reach done.
// Throughput: one beat per cycle; every command runs the same pipeline length.
// The divider is a chain of PART_WIDTH+1 cells, one quotient bit per cell.
// busy stays low; the receiver cannot stall, so results never back up.
// Reset clears the valid line only; no result is produced until a start beat enters.
`default_nettype none
module complex_arith_unit_top #(
	parameter int PART_WIDTH = cau_pkg::PART_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [1:0]                   cmd,
	input  wire  signed [PART_WIDTH-1:0] a_re,
	input  wire  signed [PART_WIDTH-1:0] a_im,
	input  wire  signed [PART_WIDTH-1:0] b_re,
	input  wire  signed [PART_WIDTH-1:0] b_im,
	output logic                         done,
	output logic signed [PART_WIDTH-1:0] res_re,
	output logic signed [PART_WIDTH-1:0] res_im,
	output logic                         saturated,
	output logic                         div_zero
);
	localparam int W   = PART_WIDTH;
	localparam int MW  = 2 * W + 1;
	localparam int RW  = 2 * W;
	localparam int XW  = 2 * W + FRAC_BITS;
	localparam int NC  = W + 1;
	localparam int LAT = W + 5;

	// returns {clamp flag, value}
	function automatic logic [W:0] sat_fn(input logic neg, input logic [MW-1:0] mag);
		logic [MW-1:0] pos_lim;
		logic [MW-1:0] neg_lim;
		logic [MW-1:0] negv;
		pos_lim = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
		neg_lim = pos_lim + {{(MW-1){1'b0}}, 1'b1};
		negv    = ~mag + {{(MW-1){1'b0}}, 1'b1};
		if (!neg) begin
			if (mag > pos_lim) return {1'b1, 1'b0, {(W-1){1'b1}}};
			return {1'b0, mag[W-1:0]};
		end
		if (mag > neg_lim) return {1'b1, 1'b1, {(W-1){1'b0}}};
		return {1'b0, negv[W-1:0]};
	endfunction

	function automatic logic [MW-1:0] abs_fn(input logic [MW-1:0] v);
		return v[MW-1] ? (~v + {{(MW-1){1'b0}}, 1'b1}) : v;
	endfunction

	assign busy = 1'b0;

	// ---- stage 1: products and sums or differences
	logic                v_s1;
	cau_pkg::cmd_t       cmd_s1;
	logic signed [RW-1:0] rr_s1, ii_s1, ri_s1, ir_s1, bb_r_s1, bb_i_s1;
	logic signed [W:0]   sre_s1, sim_s1;
	cau_pkg::cmd_t       cmd_in;

	assign cmd_in = cau_pkg::cmd_t'(cmd);

	always_ff @(posedge clk) begin
		cmd_s1  <= cmd_in;
		rr_s1   <= a_re * b_re;
		ii_s1   <= a_im * b_im;
		ri_s1   <= a_re * b_im;
		ir_s1   <= a_im * b_re;
		bb_r_s1 <= b_re * b_re;
		bb_i_s1 <= b_im * b_im;
		if (cmd_in == cau_pkg::CMD_ADD) begin
			sre_s1 <= {a_re[W-1], a_re} + {b_re[W-1], b_re};
			sim_s1 <= {a_im[W-1], a_im} + {b_im[W-1], b_im};
		end else begin
			sre_s1 <= {a_re[W-1], a_re} - {b_re[W-1], b_re};
			sim_s1 <= {a_im[W-1], a_im} - {b_im[W-1], b_im};
		end
	end

	// ---- stage 2: combine products, finish add/sub/mul
	logic [MW-1:0] mre, mim, nre, nim, are_x, aim_x, mre_a, mim_a;
	logic [RW-1:0] dsum;
	logic [W:0]    pre_re, pre_im;

	always_comb begin
		mre   = {rr_s1[RW-1], rr_s1} - {ii_s1[RW-1], ii_s1};
		mim   = {ri_s1[RW-1], ri_s1} + {ir_s1[RW-1], ir_s1};
		nre   = {rr_s1[RW-1], rr_s1} + {ii_s1[RW-1], ii_s1};
		nim   = {ir_s1[RW-1], ir_s1} - {ri_s1[RW-1], ri_s1};
		dsum  = bb_r_s1[RW-1:0] + bb_i_s1[RW-1:0];
		are_x = {{W{sre_s1[W]}}, sre_s1};
		aim_x = {{W{sim_s1[W]}}, sim_s1};
		mre_a = abs_fn(mre) >> FRAC_BITS;
		mim_a = abs_fn(mim) >> FRAC_BITS;
		if (cmd_s1 == cau_pkg::CMD_MUL) begin
			pre_re = sat_fn(mre[MW-1], mre_a);
			pre_im = sat_fn(mim[MW-1], mim_a);
		end else begin
			pre_re = sat_fn(are_x[MW-1], abs_fn(are_x));
			pre_im = sat_fn(aim_x[MW-1], abs_fn(aim_x));
		end
	end

	logic          v_s2;
	cau_pkg::cmd_t cmd_s2;
	logic [W:0]    pre_re_s2, pre_im_s2;
	logic [RW-1:0] nmag_re_s2, nmag_im_s2, d_s2;
	logic          ng_re_s2, ng_im_s2;
	logic [MW-1:0] nre_a, nim_a;

	assign nre_a = abs_fn(nre);
	assign nim_a = abs_fn(nim);

	always_ff @(posedge clk) begin
		cmd_s2     <= cmd_s1;
		pre_re_s2  <= pre_re;
		pre_im_s2  <= pre_im;
		nmag_re_s2 <= nre_a[RW-1:0];
		nmag_im_s2 <= nim_a[RW-1:0];
		ng_re_s2   <= nre[MW-1];
		ng_im_s2   <= nim[MW-1];
		d_s2       <= dsum;
	end

	// ---- stage 3: split scaled dividend, detect quotient overflow and zero divisor
	logic [XW-1:0] x_re, x_im, top_re, top_im;

	always_comb begin
		x_re   = XW'(nmag_re_s2) << FRAC_BITS;
		x_im   = XW'(nmag_im_s2) << FRAC_BITS;
		top_re = x_re >> NC;
		top_im = x_im >> NC;
	end

	logic          v_s3;
	cau_pkg::cmd_t cmd_s3;
	logic [W:0]    pre_re_s3, pre_im_s3, low_re_s3, low_im_s3;
	logic [RW-1:0] rem_re_s3, rem_im_s3, d_s3;
	logic          ng_re_s3, ng_im_s3, ov_re_s3, ov_im_s3, dz_s3;

	always_ff @(posedge clk) begin
		cmd_s3    <= cmd_s2;
		pre_re_s3 <= pre_re_s2;
		pre_im_s3 <= pre_im_s2;
		low_re_s3 <= x_re[W:0];
		low_im_s3 <= x_im[W:0];
		rem_re_s3 <= top_re[RW-1:0];
		rem_im_s3 <= top_im[RW-1:0];
		ov_re_s3  <= top_re >= XW'(d_s2);
		ov_im_s3  <= top_im >= XW'(d_s2);
		ng_re_s3  <= ng_re_s2;
		ng_im_s3  <= ng_im_s2;
		d_s3      <= d_s2;
		dz_s3     <= d_s2 == '0;
	end

	// ---- divider cell chain
	logic [RW-1:0] rem_re_c [NC];
	logic [RW-1:0] rem_im_c [NC];
	logic [W:0]    x_re_c   [NC];
	logic [W:0]    x_im_c   [NC];
	logic [W:0]    q_re_c   [NC];
	logic [W:0]    q_im_c   [NC];
	logic [RW-1:0] d_re_c   [NC];
	logic [RW-1:0] d_im_c   [NC];

	genvar k;
	generate
		for (k = 0; k < NC; k++) begin : g_cell
			if (k == 0) begin : g_head
				cau_div_cell #(.PART_WIDTH(W)) u_re (
					.clk(clk), .rem_i(rem_re_s3), .x_i(low_re_s3), .q_i('0), .d_i(d_s3),
					.rem_o(rem_re_c[k]), .x_o(x_re_c[k]), .q_o(q_re_c[k]), .d_o(d_re_c[k])
				);
				cau_div_cell #(.PART_WIDTH(W)) u_im (
					.clk(clk), .rem_i(rem_im_s3), .x_i(low_im_s3), .q_i('0), .d_i(d_s3),
					.rem_o(rem_im_c[k]), .x_o(x_im_c[k]), .q_o(q_im_c[k]), .d_o(d_im_c[k])
				);
			end else begin : g_body
				cau_div_cell #(.PART_WIDTH(W)) u_re (
					.clk(clk), .rem_i(rem_re_c[k-1]), .x_i(x_re_c[k-1]), .q_i(q_re_c[k-1]),
					.d_i(d_re_c[k-1]),
					.rem_o(rem_re_c[k]), .x_o(x_re_c[k]), .q_o(q_re_c[k]), .d_o(d_re_c[k])
				);
				cau_div_cell #(.PART_WIDTH(W)) u_im (
					.clk(clk), .rem_i(rem_im_c[k-1]), .x_i(x_im_c[k-1]), .q_i(q_im_c[k-1]),
					.d_i(d_im_c[k-1]),
					.rem_o(rem_im_c[k]), .x_o(x_im_c[k]), .q_o(q_im_c[k]), .d_o(d_im_c[k])
				);
			end
		end
	endgenerate

	// sideband travels alongside the cells
	logic          cv_q     [NC];
	cau_pkg::cmd_t cmd_c_q  [NC];
	logic [W:0]    pre_re_q [NC];
	logic [W:0]    pre_im_q [NC];
	logic          ng_re_q  [NC];
	logic          ng_im_q  [NC];
	logic          ov_re_q  [NC];
	logic          ov_im_q  [NC];
	logic          dz_q     [NC];

	always_ff @(posedge clk) begin
		cmd_c_q[0]  <= cmd_s3;
		pre_re_q[0] <= pre_re_s3;
		pre_im_q[0] <= pre_im_s3;
		ng_re_q[0]  <= ng_re_s3;
		ng_im_q[0]  <= ng_im_s3;
		ov_re_q[0]  <= ov_re_s3;
		ov_im_q[0]  <= ov_im_s3;
		dz_q[0]     <= dz_s3;
		for (int i = 1; i < NC; i++) begin
			cmd_c_q[i]  <= cmd_c_q[i-1];
			pre_re_q[i] <= pre_re_q[i-1];
			pre_im_q[i] <= pre_im_q[i-1];
			ng_re_q[i]  <= ng_re_q[i-1];
			ng_im_q[i]  <= ng_im_q[i-1];
			ov_re_q[i]  <= ov_re_q[i-1];
			ov_im_q[i]  <= ov_im_q[i-1];
			dz_q[i]     <= dz_q[i-1];
		end
	end

	// ---- output stage
	logic [W:0]    fin_re, fin_im;
	logic [MW-1:0] qm_re, qm_im;

	always_comb begin
		qm_re = ov_re_q[NC-1] ? {MW{1'b1}} : MW'(q_re_c[NC-1]);
		qm_im = ov_im_q[NC-1] ? {MW{1'b1}} : MW'(q_im_c[NC-1]);
		if (cmd_c_q[NC-1] != cau_pkg::CMD_DIV) begin
			fin_re = pre_re_q[NC-1];
			fin_im = pre_im_q[NC-1];
		end else if (dz_q[NC-1]) begin
			fin_re = '0;
			fin_im = '0;
		end else begin
			fin_re = sat_fn(ng_re_q[NC-1], qm_re);
			fin_im = sat_fn(ng_im_q[NC-1], qm_im);
		end
	end

	always_ff @(posedge clk) begin
		res_re    <= fin_re[W-1:0];
		res_im    <= fin_im[W-1:0];
		saturated <= fin_re[W] | fin_im[W];
		div_zero  <= (cmd_c_q[NC-1] == cau_pkg::CMD_DIV) & dz_q[NC-1];
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int i = 0; i < NC; i++) cv_q[i] <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			cv_q[0] <= v_s3;
			for (int i = 1; i < NC; i++) cv_q[i] <= cv_q[i-1];
			done <= cv_q[NC-1];
		end
	end

	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("accepted beat produced no result");
	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("result without a beat");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_zero) |-> (res_re == '0 && res_im == '0 && !saturated))
		else $error("divide by zero result not cleared");
endmodule
`default_nettype wire

/* verif/cau_checker.sv */
// Checker for the complex arithmetic unit: predicts each result and compares it with the block.
`timescale 1ns / 1ps
`default_nettype none
module cau_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               busy,
	input  wire  [1:0]        cmd,
	input  wire  signed [15:0] a_re,
	input  wire  signed [15:0] a_im,
	input  wire  signed [15:0] b_re,
	input  wire  signed [15:0] b_im,
	input  wire               done,
	input  wire  signed [15:0] res_re,
	input  wire  signed [15:0] res_im,
	input  wire               saturated,
	input  wire               div_zero,
	output int                fail_count,
	output int                pending
);
	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               sat;
		logic               dz;
	} cplx_result_t;

	cplx_result_t result_fifo[$];
	int mismatches = 0;

	// Clamp a wide exact value to 16 bits, flag when clamped.
	function automatic logic signed [15:0] clamp16(input longint v, inout logic flag);
		if (v > 32767) begin
			flag = 1'b1;
			return 16'sd32767;
		end
		if (v < -32768) begin
			flag = 1'b1;
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Truncate toward zero the value n * 2^8 / d with d > 0.
	function automatic longint quot_q8(input longint n, input longint d);
		longint mag;
		mag = ((n < 0 ? -n : n) <<< 8) / d;
		return n < 0 ? -mag : mag;
	endfunction

	function automatic cplx_result_t compute_result(input cau_pkg::cmd_t op,
			input longint ar, input longint ai, input longint br, input longint bi);
		cplx_result_t r;
		longint vr, vi, den;
		r = '0;
		vr = 0;
		vi = 0;
		case (op)
			cau_pkg::CMD_ADD: begin
				vr = ar + br;
				vi = ai + bi;
			end
			cau_pkg::CMD_SUB: begin
				vr = ar - br;
				vi = ai - bi;
			end
			cau_pkg::CMD_MUL: begin
				vr = ar * br - ai * bi;
				vi = ar * bi + ai * br;
				vr = vr < 0 ? -((-vr) >>> 8) : vr >>> 8;
				vi = vi < 0 ? -((-vi) >>> 8) : vi >>> 8;
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					vr = quot_q8(ar * br + ai * bi, den);
					vi = quot_q8(ai * br - ar * bi, den);
				end
			end
		endcase
		if (!r.dz) begin
			r.re = clamp16(vr, r.sat);
			r.im = clamp16(vi, r.sat);
		end
		return r;
	endfunction

	assign pending = result_fifo.size();

	always @(posedge clk or negedge arst_n) begin
		cplx_result_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (done) begin
				if (result_fifo.size() == 0) begin
					fail_count <= fail_count + 1;
					if (mismatches < 10)
						$display("ERROR: unexpected result beat re=%0d im=%0d", res_re, res_im);
					mismatches++;
				end else begin
					want = result_fifo.pop_front();
					if (want.re !== res_re || want.im !== res_im ||
							want.sat !== saturated || want.dz !== div_zero) begin
						fail_count <= fail_count + 1;
						if (mismatches < 10)
							$display("ERROR: exp re=%0d im=%0d sat=%0b dz=%0b got re=%0d im=%0d sat=%0b dz=%0b",
								want.re, want.im, want.sat, want.dz,
								res_re, res_im, saturated, div_zero);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				result_fifo.push_back(compute_result(cau_pkg::cmd_t'(cmd),
					a_re, a_im, b_re, b_im));
		end
	end
endmodule
`default_nettype wire

/* verif/tb_complex_arith_unit_top.sv */
// Testbench top for the complex arithmetic unit: drives command beats and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_complex_arith_unit_top;
	localparam int LATENCY   = 21;
	localparam int CYCLE_CAP = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] cmd = cau_pkg::CMD_ADD;
	logic signed [15:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	wire busy, done, saturated, div_zero;
	wire signed [15:0] res_re, res_im;
	int fail_count, pending;
	int cycles = 0;
	int idle_pct = 0;

	complex_arith_unit_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
		.res_re(res_re), .res_im(res_im), .saturated(saturated), .div_zero(div_zero)
	);

	cau_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
		.res_re(res_re), .res_im(res_im), .saturated(saturated), .div_zero(div_zero),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Random operand part, biased toward extremes and small values.
	function automatic logic [15:0] rand_part();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Present one command beat, idling first at the current rate; hold start across beats.
	task automatic send_beat(input cau_pkg::cmd_t op, input logic [15:0] ar,
			input logic [15:0] ai, input logic [15:0] br, input logic [15:0] bi);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic send_random(input int count);
		cau_pkg::cmd_t op;
		logic [15:0] ar, ai, br, bi;
		for (int n = 0; n < count; n++) begin
			op = cau_pkg::cmd_t'($urandom_range(0, 3));
			ar = rand_part();
			ai = rand_part();
			br = rand_part();
			bi = rand_part();
			// Hit zero divisor now and then.
			if (op == cau_pkg::CMD_DIV && $urandom_range(0, 15) == 0) begin
				br = '0;
				bi = '0;
			end
			send_beat(op, ar, ai, br, bi);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every command, saturation and zero divisor.
		for (int c = 0; c < 4; c++) begin
			send_beat(cau_pkg::cmd_t'(c), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
			send_beat(cau_pkg::cmd_t'(c), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			send_beat(cau_pkg::cmd_t'(c), 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
			send_beat(cau_pkg::cmd_t'(c), 16'h0100, 16'hff00, 16'h0080, 16'h0001);
		end
		send_beat(cau_pkg::CMD_DIV, 16'h1234, 16'hedcb, 16'h0000, 16'h0000);
		send_beat(cau_pkg::CMD_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_beat(cau_pkg::CMD_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
		send_beat(cau_pkg::CMD_MUL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

		// Drain fully before continuing.
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);

		idle_pct = 23;
		send_random(370);
		idle_pct = 59;
		send_random(370);
		idle_pct = 0;
		send_random(370);
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
